### rtl/pcm_frame_to_tone_runs_defines.svh
// ----------------------------------------------------------------------------
// pcm_frame_to_tone_runs_defines.svh
// Assertion macros used by the checker file of the tone run block.
// ----------------------------------------------------------------------------
`ifndef PCM_FRAME_TO_TONE_RUNS_DEFINES_SVH
`define PCM_FRAME_TO_TONE_RUNS_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define PFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pft: same-cycle property violated");

// Next-cycle implication, masked while reset is asserted
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pft: next-cycle property violated");

`endif

### rtl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Types, constants and sample helpers for the PCM frame to tone run block.
// ----------------------------------------------------------------------------
package pft_pkg;

	// Register map (word index = paddr[4:2])
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_SIXTEEN_BIT    = 3'd0;
	localparam logic [2:0] REG_STEREO         = 3'd1;
	localparam logic [2:0] REG_FRAME_STRIDE   = 3'd2;
	localparam logic [2:0] REG_STEP_COUNT     = 3'd3;
	localparam logic [2:0] REG_TICKS_PER_STEP = 3'd4;

	// Field widths
	localparam int unsigned STRIDE_W = 20;
	localparam int unsigned STEPS_W  = 13;
	localparam int unsigned TPS_W    = 7;
	localparam int unsigned FREQ_W   = 11;
	localparam int unsigned TICKS_W  = 10;
	localparam int unsigned DEV_W    = 8;

	// Register limits and reset values
	localparam logic [STEPS_W-1:0] STEPS_MAX   = 13'd4096;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 13'd256;
	localparam logic [TPS_W-1:0]   TPS_MAX     = 7'd64;

	// Tone mapping
	localparam logic [DEV_W-1:0]  DEV_SILENT = 8'd4;
	localparam logic [FREQ_W-1:0] FREQ_BASE  = 11'd180;

	// Longest run in ticks
	localparam int unsigned MAX_RUN_TICKS_DEF = 512;

	// Result queue
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic                sixteen_bit;
		logic                stereo;
		logic [STRIDE_W-1:0] stride;
		logic [STEPS_W-1:0]  steps;
		logic [TPS_W-1:0]    tps;
	} cfg_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [TICKS_W-1:0] ticks;
		logic               last;
	} tone_t;

	// Up to two words written into the result queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		tone_t      first;
		tone_t      second;
	} push_t;

	typedef struct packed {
		logic room;
	} queue_stat_t;

	// Deviation of one sample from silence
	function automatic logic [DEV_W-1:0] dev_of(input logic [15:0] raw,
			input logic sixteen);
		logic [15:0] mag;
		logic [7:0]  b;
		mag = raw[15] ? (16'd0 - raw) : raw;
		b   = raw[7:0];
		if (sixteen) begin
			dev_of = mag[15:8];
		end else if (b[7]) begin
			dev_of = {1'b0, b[6:0]};
		end else begin
			dev_of = 8'd128 - b;
		end
	endfunction

	// Frequency for a deviation: silence below threshold, else base + 12 * dev
	function automatic logic [FREQ_W-1:0] freq_of(input logic [DEV_W-1:0] dev);
		logic [FREQ_W-1:0] d;
		d = {{(FREQ_W-DEV_W){1'b0}}, dev};
		if (dev < DEV_SILENT) begin
			freq_of = '0;
		end else begin
			freq_of = FREQ_BASE + (d << 3) + (d << 2);
		end
	endfunction

endpackage

### rtl/pcm_frame_to_tone_runs.sv
// ----------------------------------------------------------------------------
// pcm_frame_to_tone_runs
// Turns a stream of PCM frames into (frequency, ticks) tone runs.
// ----------------------------------------------------------------------------
// Usage
//   Frame channel: frame_valid / frame_stall carry left_raw and right_raw,
//   one frame per word. Tone channel: tone_valid / tone_stall carry
//   tone_freq, tone_ticks and last_tone. The APB port holds the sample
//   format, stride, step count and ticks per step; write it only while idle.
//   Throughput: one frame per cycle while the queue has room. A frame is
//   held in the frame register, is processed in one pass and its words
//   land in a four-entry result queue, whose head is the tone word on the
//   port. The final frame of a clip can give two words; the queue absorbs
//   them and the tone port drains one word per cycle unless stalled.
//   If the receiver stalls, the queue fills; once it cannot take two more
//   words the frame register holds and frame_stall rises.
//   Reset clears the stride phase, step count and open run, empties the
//   queue and returns the registers to their defaults. Once the step count
//   is reached frames are taken and dropped until the next reset.
// ----------------------------------------------------------------------------
module pcm_frame_to_tone_runs #(
	parameter int unsigned MAX_RUN_TICKS = pft_pkg::MAX_RUN_TICKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pft_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  logic [15:0]                   left_raw,
	input  logic [15:0]                   right_raw,
	output logic                          tone_valid,
	input  logic                          tone_stall,
	output logic [pft_pkg::FREQ_W-1:0]    tone_freq,
	output logic [pft_pkg::TICKS_W-1:0]   tone_ticks,
	output logic                          last_tone
);

	pft_pkg::cfg_t         cfg;
	pft_pkg::push_t        push;
	pft_pkg::queue_stat_t  stat;
	pft_pkg::tone_t        head;

	pft_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pft_core #(
		.MAX_RUN_TICKS (MAX_RUN_TICKS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.left_raw    (left_raw),
		.right_raw   (right_raw),
		.stat        (stat),
		.push        (push)
	);

	pft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.stat       (stat),
		.tone_valid (tone_valid),
		.tone_stall (tone_stall),
		.head       (head)
	);

	assign tone_freq  = head.freq;
	assign tone_ticks = head.ticks;
	assign last_tone  = head.last;

endmodule

### rtl/pft_cfg.sv
// ----------------------------------------------------------------------------
// pft_cfg
// APB register file; presents clamped working values to the datapath.
// ----------------------------------------------------------------------------
module pft_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pft_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output pft_pkg::cfg_t               cfg
);

	logic                          sixteen_q;
	logic                          stereo_q;
	logic [pft_pkg::STRIDE_W-1:0]  stride_q;
	logic [pft_pkg::STEPS_W-1:0]   steps_q;
	logic [pft_pkg::TPS_W-1:0]     tps_q;
	logic [2:0]                    idx;
	logic                          wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sixteen_q <= 1'b0;
			stereo_q  <= 1'b0;
			stride_q  <= 20'd1;
			steps_q   <= pft_pkg::STEPS_RESET;
			tps_q     <= 7'd1;
		end else if (wr) begin
			unique case (idx)
				pft_pkg::REG_SIXTEEN_BIT:    sixteen_q <= pwdata[0];
				pft_pkg::REG_STEREO:         stereo_q  <= pwdata[0];
				pft_pkg::REG_FRAME_STRIDE:   stride_q  <= pwdata[pft_pkg::STRIDE_W-1:0];
				pft_pkg::REG_STEP_COUNT:     steps_q   <= pwdata[pft_pkg::STEPS_W-1:0];
				pft_pkg::REG_TICKS_PER_STEP: tps_q     <= pwdata[pft_pkg::TPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			pft_pkg::REG_SIXTEEN_BIT:    prdata[0] = sixteen_q;
			pft_pkg::REG_STEREO:         prdata[0] = stereo_q;
			pft_pkg::REG_FRAME_STRIDE:   prdata[pft_pkg::STRIDE_W-1:0] = stride_q;
			pft_pkg::REG_STEP_COUNT:     prdata[pft_pkg::STEPS_W-1:0] = steps_q;
			pft_pkg::REG_TICKS_PER_STEP: prdata[pft_pkg::TPS_W-1:0] = tps_q;
			default: ;
		endcase
	end

	// Clamp to working ranges: zero acts as one, oversize saturates
	always_comb begin
		cfg.sixteen_bit = sixteen_q;
		cfg.stereo      = stereo_q;
		cfg.stride      = (stride_q == '0) ? 20'd1 : stride_q;
		if (steps_q == '0) begin
			cfg.steps = 13'd1;
		end else if (steps_q > pft_pkg::STEPS_MAX) begin
			cfg.steps = pft_pkg::STEPS_MAX;
		end else begin
			cfg.steps = steps_q;
		end
		if (tps_q == '0) begin
			cfg.tps = 7'd1;
		end else if (tps_q > pft_pkg::TPS_MAX) begin
			cfg.tps = pft_pkg::TPS_MAX;
		end else begin
			cfg.tps = tps_q;
		end
	end

endmodule

### rtl/pft_queue.sv
// ----------------------------------------------------------------------------
// pft_queue
// Small result queue: takes up to two words a cycle, gives one a cycle while not stalled.
// ----------------------------------------------------------------------------
module pft_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pft_pkg::push_t        push,
	output pft_pkg::queue_stat_t  stat,
	output logic                  tone_valid,
	input  logic                  tone_stall,
	output pft_pkg::tone_t        head
);

	localparam int unsigned PTR_W = $clog2(pft_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;
	localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(pft_pkg::QUEUE_DEPTH - 2);

	pft_pkg::tone_t      mem [pft_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    rp_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pop;
	logic [PTR_W-1:0]    wp_next;

	assign tone_valid = (cnt_q != '0);
	assign pop        = tone_valid && !tone_stall;
	assign head       = mem[rp_q];
	assign stat.room  = (cnt_q <= ROOM_LIMIT);
	assign wp_next    = wp_q + PTR_W'(1);

	// Store incoming words
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wp_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wp_next] <= push.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push.count);
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

### rtl/pft_core.sv
// ----------------------------------------------------------------------------
// pft_core
// Frame register, stride and step counting, and run merging.
// ----------------------------------------------------------------------------
module pft_core #(
	parameter int unsigned MAX_RUN_TICKS = pft_pkg::MAX_RUN_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pft_pkg::cfg_t         cfg,
	input  logic                  frame_valid,
	output logic                  frame_stall,
	input  logic [15:0]           left_raw,
	input  logic [15:0]           right_raw,
	input  pft_pkg::queue_stat_t  stat,
	output pft_pkg::push_t        push
);

	localparam logic [pft_pkg::TICKS_W:0] RUN_LIMIT = (pft_pkg::TICKS_W+1)'(MAX_RUN_TICKS);

	logic                          v_s1;
	logic [15:0]                   left_s1;
	logic [15:0]                   right_s1;
	logic [pft_pkg::STRIDE_W-1:0]  phase_q;
	logic [pft_pkg::STEPS_W-1:0]   kept_q;
	logic [pft_pkg::FREQ_W-1:0]    pend_freq_q;
	logic [pft_pkg::TICKS_W-1:0]   pend_ticks_q;

	logic                          adv;
	logic                          accept;
	logic                          active;
	logic                          keep;
	logic [pft_pkg::STRIDE_W:0]    phase_inc;
	logic [pft_pkg::DEV_W-1:0]     dev_l;
	logic [pft_pkg::DEV_W-1:0]     dev_r;
	logic [pft_pkg::DEV_W:0]       dev_sum;
	logic [pft_pkg::DEV_W-1:0]     dev;
	logic [pft_pkg::FREQ_W-1:0]    freq;
	logic [pft_pkg::TICKS_W:0]     tick_sum;
	logic [pft_pkg::TICKS_W-1:0]   tps_ext;
	logic [pft_pkg::STEPS_W-1:0]   kept_inc;

	logic [pft_pkg::STRIDE_W-1:0]  phase_d;
	logic [pft_pkg::STEPS_W-1:0]   kept_d;
	logic [pft_pkg::FREQ_W-1:0]    pend_freq_d;
	logic [pft_pkg::TICKS_W-1:0]   pend_ticks_d;
	logic                          emit_run;
	logic                          emit_last;
	pft_pkg::tone_t                run_word;
	pft_pkg::tone_t                last_word;

	// Handshake: the frame register frees up whenever its word is processed
	assign adv         = v_s1 && stat.room;
	assign frame_stall = v_s1 && !stat.room;
	assign accept      = frame_valid && !frame_stall;

	// Hold the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1  <= left_raw;
			right_s1 <= right_raw;
		end
	end

	// Deviation and frequency of the held frame
	always_comb begin
		dev_l   = pft_pkg::dev_of(left_s1, cfg.sixteen_bit);
		dev_r   = pft_pkg::dev_of(right_s1, cfg.sixteen_bit);
		dev_sum = {1'b0, dev_l} + {1'b0, dev_r};
		dev     = cfg.stereo ? dev_sum[pft_pkg::DEV_W:1] : dev_l;
		freq    = pft_pkg::freq_of(dev);
	end

	// Stride, step count and run merging
	always_comb begin
		active    = (kept_q < cfg.steps);
		keep      = (phase_q == '0);
		phase_inc = {1'b0, phase_q} + (pft_pkg::STRIDE_W+1)'(1);
		tps_ext   = pft_pkg::TICKS_W'(cfg.tps);
		tick_sum  = {1'b0, pend_ticks_q} + {1'b0, tps_ext};
		kept_inc  = kept_q + pft_pkg::STEPS_W'(1);

		phase_d      = phase_q;
		kept_d       = kept_q;
		pend_freq_d  = pend_freq_q;
		pend_ticks_d = pend_ticks_q;
		emit_run     = 1'b0;
		emit_last    = 1'b0;

		run_word.freq  = pend_freq_q;
		run_word.ticks = pend_ticks_q;
		run_word.last  = 1'b0;

		if (active) begin
			phase_d = (phase_inc >= {1'b0, cfg.stride}) ? '0
				: phase_inc[pft_pkg::STRIDE_W-1:0];
			if (keep) begin
				if (pend_ticks_q == '0) begin
					pend_freq_d  = freq;
					pend_ticks_d = tps_ext;
				end else if (freq == pend_freq_q && tick_sum <= RUN_LIMIT) begin
					pend_ticks_d = tick_sum[pft_pkg::TICKS_W-1:0];
				end else begin
					emit_run     = 1'b1;
					pend_freq_d  = freq;
					pend_ticks_d = tps_ext;
				end
				kept_d = kept_inc;
				// Final step: flush the open run and close the clip
				if (kept_inc >= cfg.steps) begin
					emit_last    = 1'b1;
					pend_freq_d  = '0;
					pend_ticks_d = '0;
				end
			end
		end

		last_word.freq  = emit_last ? ((emit_run || pend_ticks_q == '0 ||
			freq != pend_freq_q || tick_sum > RUN_LIMIT) ? freq : pend_freq_q) : '0;
		last_word.ticks = (emit_run || pend_ticks_q == '0 || freq != pend_freq_q ||
			tick_sum > RUN_LIMIT) ? tps_ext : tick_sum[pft_pkg::TICKS_W-1:0];
		last_word.last  = 1'b1;

		push.count  = 2'd0;
		push.first  = run_word;
		push.second = last_word;
		if (adv) begin
			if (emit_run && emit_last) begin
				push.count = 2'd2;
			end else if (emit_run) begin
				push.count = 2'd1;
			end else if (emit_last) begin
				push.count = 2'd1;
				push.first = last_word;
			end
		end
	end

	// Advance state on each processed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			kept_q       <= '0;
			pend_freq_q  <= '0;
			pend_ticks_q <= '0;
		end else if (adv) begin
			phase_q      <= phase_d;
			kept_q       <= kept_d;
			pend_freq_q  <= pend_freq_d;
			pend_ticks_q <= pend_ticks_d;
		end
	end

endmodule

### rtl/pft_checker.sv
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks on the tone channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pcm_frame_to_tone_runs_defines.svh"

module pft_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tone_valid,
	input  logic                          tone_stall,
	input  logic [pft_pkg::FREQ_W-1:0]    tone_freq,
	input  logic [pft_pkg::TICKS_W-1:0]   tone_ticks,
	input  logic                          last_tone
);

	// Hold a stalled word
	`PFT_ASSERT_NEXT(a_valid_held, clk, arst_n, tone_valid && tone_stall, tone_valid)
	`PFT_ASSERT_NEXT(a_word_held, clk, arst_n, tone_valid && tone_stall, $stable(tone_freq) && $stable(tone_ticks) && $stable(last_tone))

	// Every run carries at least one tick
	`PFT_ASSERT_NOW(a_ticks_nonzero, clk, arst_n, tone_valid, tone_ticks != 0)

	// Frequency is silence or lies in the tone band
	`PFT_ASSERT_NOW(a_freq_band, clk, arst_n, tone_valid, (tone_freq == 0) || (tone_freq >= 228 && tone_freq <= 1716))

endmodule

bind pcm_frame_to_tone_runs pft_checker u_pft_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tone_valid (tone_valid),
	.tone_stall (tone_stall),
	.tone_freq  (tone_freq),
	.tone_ticks (tone_ticks),
	.last_tone  (last_tone)
);
